// ===== rtl/ps2l_pkg.sv =====
// ps2l_pkg: shared types, scan codes and key tables for the set-1 line input block
// depends on nothing; imported by every module of the block
`default_nettype none

package ps2l_pkg;

  // fixed field widths
  localparam int SCAN_W = 8;
  localparam int CHAR_W = 7;
  localparam int ACT_W  = 3;
  localparam int POS_W  = 9;

  // default line capacity in slots
  localparam int LINE_LEN_DEF = 256;

  // set-1 scan codes with a special meaning
  localparam logic [SCAN_W-1:0] SC_ENTER       = 8'h1C;
  localparam logic [SCAN_W-1:0] SC_BACKSPACE   = 8'h0E;
  localparam logic [SCAN_W-1:0] SC_LSHIFT_MAKE = 8'h2A;
  localparam logic [SCAN_W-1:0] SC_RSHIFT_MAKE = 8'h36;
  localparam logic [SCAN_W-1:0] SC_LSHIFT_BRK  = 8'hAA;
  localparam logic [SCAN_W-1:0] SC_RSHIFT_BRK  = 8'hB6;

  // characters produced directly
  localparam logic [CHAR_W-1:0] CH_NUL     = 7'h00;
  localparam logic [CHAR_W-1:0] CH_NEWLINE = 7'h0A;

  // result action codes
  typedef enum logic [ACT_W-1:0] {
    ACT_STORED        = 3'd0,
    ACT_ERASED        = 3'd1,
    ACT_ERASE_IGNORED = 3'd2,
    ACT_LINE_END      = 3'd3,
    ACT_DROPPED       = 3'd4
  } action_t;

  // one decoded result plus its presence flag
  typedef struct packed {
    logic                valid;
    logic [CHAR_W-1:0]   ascii_char;
    action_t             action;
    logic [POS_W-1:0]    line_position;
  } result_t;

  // us layout, no shift
  function automatic logic [CHAR_W-1:0] plain_char(input logic [CHAR_W-1:0] code);
    logic [CHAR_W-1:0] ch;
    case (code)
      7'h02: ch = 7'h31;  7'h03: ch = 7'h32;  7'h04: ch = 7'h33;  7'h05: ch = 7'h34;
      7'h06: ch = 7'h35;  7'h07: ch = 7'h36;  7'h08: ch = 7'h37;  7'h09: ch = 7'h38;
      7'h0A: ch = 7'h39;  7'h0B: ch = 7'h30;  7'h0C: ch = 7'h2D;  7'h0D: ch = 7'h3D;
      7'h10: ch = 7'h71;  7'h11: ch = 7'h77;  7'h12: ch = 7'h65;  7'h13: ch = 7'h72;
      7'h14: ch = 7'h74;  7'h15: ch = 7'h79;  7'h16: ch = 7'h75;  7'h17: ch = 7'h69;
      7'h18: ch = 7'h6F;  7'h19: ch = 7'h70;  7'h1A: ch = 7'h5B;  7'h1B: ch = 7'h5D;
      7'h1E: ch = 7'h61;  7'h1F: ch = 7'h73;  7'h20: ch = 7'h64;  7'h21: ch = 7'h66;
      7'h22: ch = 7'h67;  7'h23: ch = 7'h68;  7'h24: ch = 7'h6A;  7'h25: ch = 7'h6B;
      7'h26: ch = 7'h6C;  7'h27: ch = 7'h3B;  7'h28: ch = 7'h27;  7'h2B: ch = 7'h5C;
      7'h2C: ch = 7'h7A;  7'h2D: ch = 7'h78;  7'h2E: ch = 7'h63;  7'h2F: ch = 7'h76;
      7'h30: ch = 7'h62;  7'h31: ch = 7'h6E;  7'h32: ch = 7'h6D;  7'h33: ch = 7'h2C;
      7'h34: ch = 7'h2E;  7'h35: ch = 7'h2F;  7'h39: ch = 7'h20;
      default: ch = CH_NUL;
    endcase
    return ch;
  endfunction

  // us layout, shift held
  function automatic logic [CHAR_W-1:0] shift_char(input logic [CHAR_W-1:0] code);
    logic [CHAR_W-1:0] ch;
    case (code)
      7'h02: ch = 7'h21;  7'h03: ch = 7'h40;  7'h04: ch = 7'h23;  7'h05: ch = 7'h24;
      7'h06: ch = 7'h25;  7'h07: ch = 7'h5E;  7'h08: ch = 7'h26;  7'h09: ch = 7'h2A;
      7'h0A: ch = 7'h28;  7'h0B: ch = 7'h29;  7'h0C: ch = 7'h5F;  7'h0D: ch = 7'h2B;
      7'h10: ch = 7'h51;  7'h11: ch = 7'h57;  7'h12: ch = 7'h45;  7'h13: ch = 7'h52;
      7'h14: ch = 7'h54;  7'h15: ch = 7'h59;  7'h16: ch = 7'h55;  7'h17: ch = 7'h49;
      7'h18: ch = 7'h4F;  7'h19: ch = 7'h50;  7'h1A: ch = 7'h7B;  7'h1B: ch = 7'h7D;
      7'h1E: ch = 7'h41;  7'h1F: ch = 7'h53;  7'h20: ch = 7'h44;  7'h21: ch = 7'h46;
      7'h22: ch = 7'h47;  7'h23: ch = 7'h48;  7'h24: ch = 7'h4A;  7'h25: ch = 7'h4B;
      7'h26: ch = 7'h4C;  7'h27: ch = 7'h3A;  7'h28: ch = 7'h22;  7'h2B: ch = 7'h7C;
      7'h2C: ch = 7'h5A;  7'h2D: ch = 7'h58;  7'h2E: ch = 7'h43;  7'h2F: ch = 7'h56;
      7'h30: ch = 7'h42;  7'h31: ch = 7'h4E;  7'h32: ch = 7'h4D;  7'h33: ch = 7'h3C;
      7'h34: ch = 7'h3E;  7'h35: ch = 7'h3F;  7'h39: ch = 7'h20;
      default: ch = CH_NUL;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/ps2l_keymap.sv =====
// ps2l_keymap: make code to us-layout ascii translation, shifted or plain
// depends on ps2l_pkg key tables
`default_nettype none

module ps2l_keymap
  import ps2l_pkg::*;
(
  input  wire logic [CHAR_W-1:0] code,
  input  wire logic              shift,
  output logic      [CHAR_W-1:0] ch
);

  // both tables in parallel, shift picks one
  logic [CHAR_W-1:0] ch_plain;
  logic [CHAR_W-1:0] ch_shift;

  assign ch_plain = plain_char(code);
  assign ch_shift = shift_char(code);
  assign ch       = shift ? ch_shift : ch_plain;

endmodule

`default_nettype wire

// ===== rtl/ps2l_line_ctrl.sv =====
// ps2l_line_ctrl: shift flag, line slot counter and result decode for one scan byte
// depends on ps2l_pkg and ps2l_keymap
`default_nettype none

module ps2l_line_ctrl
  import ps2l_pkg::*;
#(
  parameter int LINE_LEN = LINE_LEN_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [SCAN_W-1:0] scan,
  input  wire logic              step,
  output result_t                res
);

  localparam int SLOT_W = $clog2(LINE_LEN + 1);
  localparam logic [SLOT_W-1:0] SLOT_FULL = SLOT_W'(LINE_LEN);
  localparam logic [POS_W-1:0]  POS_NONE  = POS_W'(LINE_LEN);

  logic              shift_held;
  logic              shift_held_next;
  logic [SLOT_W-1:0] write_slot;
  logic [SLOT_W-1:0] write_slot_next;
  logic [SLOT_W-1:0] slot_dec;
  logic [CHAR_W-1:0] key_char;
  logic              is_shift_make;
  logic              is_shift_brk;

  ps2l_keymap u_keymap (
    .code  (scan[CHAR_W-1:0]),
    .shift (shift_held),
    .ch    (key_char)
  );

  assign is_shift_make = (scan == SC_LSHIFT_MAKE) || (scan == SC_RSHIFT_MAKE);
  assign is_shift_brk  = (scan == SC_LSHIFT_BRK)  || (scan == SC_RSHIFT_BRK);
  assign slot_dec      = write_slot - SLOT_W'(1);

  // decode the byte into a result and the next state
  always_comb begin
    shift_held_next   = shift_held;
    write_slot_next   = write_slot;
    res.valid         = 1'b0;
    res.ascii_char    = CH_NUL;
    res.action        = ACT_STORED;
    res.line_position = POS_NONE;
    if (is_shift_make) begin
      shift_held_next = 1'b1;
    end else if (is_shift_brk) begin
      shift_held_next = 1'b0;
    end else if (!scan[SCAN_W-1]) begin
      res.valid = 1'b1;
      if (scan == SC_ENTER) begin
        res.ascii_char  = CH_NEWLINE;
        res.action      = ACT_LINE_END;
        write_slot_next = '0;
      end else if (scan == SC_BACKSPACE) begin
        if (write_slot == '0) begin
          res.action = ACT_ERASE_IGNORED;
        end else begin
          res.action        = ACT_ERASED;
          res.line_position = POS_W'(slot_dec);
          write_slot_next   = slot_dec;
        end
      end else begin
        res.ascii_char = key_char;
        if (write_slot == SLOT_FULL) begin
          res.action = ACT_DROPPED;
        end else begin
          res.line_position = POS_W'(write_slot);
          write_slot_next   = write_slot + SLOT_W'(1);
        end
      end
    end
  end

  // state advances once per consumed item
  always_ff @(posedge clk) begin
    if (rst) begin
      shift_held <= 1'b0;
      write_slot <= '0;
    end else if (step) begin
      shift_held <= shift_held_next;
      write_slot <= write_slot_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ps2_set1_line_input.sv =====
// ps2_set1_line_input: top level, input register, line control and result register
// depends on ps2l_pkg and ps2l_line_ctrl
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------
//  input    | in_valid / in_ready  | scan_byte[7:0]
//  result   | out_valid / out_ready| ascii_char[6:0], action[2:0], line_position[8:0]
//
// one item per cycle sustained while the result side does not stall; a byte waits in the input register,
// is decoded there and its result, if any, is loaded into the result register as it leaves
// shift and break bytes give no result and leave the input register even when the result stalls
// rst clears the shift flag, the slot counter and both valid flags
// a stalled result holds the input register only when that byte has a result
`default_nettype none

module ps2_set1_line_input
  import ps2l_pkg::*;
#(
  parameter int LINE_LEN = LINE_LEN_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [SCAN_W-1:0] scan_byte,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic      [CHAR_W-1:0] ascii_char,
  output logic      [ACT_W-1:0]  action,
  output logic      [POS_W-1:0]  line_position
);

  logic              s1_valid;
  logic [SCAN_W-1:0] s1_byte;
  logic              s1_adv;
  logic              out_free;
  result_t           res;

  // input register advances when its result, if any, can be loaded
  assign out_free = !out_valid || out_ready;
  assign s1_adv   = s1_valid && (!res.valid || out_free);
  assign in_ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte <= scan_byte;
    end
  end

  ps2l_line_ctrl #(
    .LINE_LEN (LINE_LEN)
  ) u_line_ctrl (
    .clk  (clk),
    .rst  (rst),
    .scan (s1_byte),
    .step (s1_adv),
    .res  (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv && res.valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && res.valid) begin
      ascii_char    <= res.ascii_char;
      action        <= res.action;
      line_position <= res.line_position;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ps2l_checker.sv =====
// ps2l_checker: port-level checks on the set-1 line input block, bound to the top level
// depends on ps2l_pkg and ps2_set1_line_input
`default_nettype none

module ps2l_checker
  import ps2l_pkg::*;
#(
  parameter int LINE_LEN = LINE_LEN_DEF
) (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [CHAR_W-1:0] ascii_char,
  input wire logic [ACT_W-1:0]  action,
  input wire logic [POS_W-1:0]  line_position
);

  localparam logic [POS_W-1:0] POS_NONE = POS_W'(LINE_LEN);

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // a stalled result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(ascii_char) && $stable(action)
      && $stable(line_position))
    else $error("stalled result changed");

  // line end always carries a newline
  a_line_end_char: assert property (@(posedge clk) disable iff (rst)
    out_valid && (action == ACT_LINE_END) |-> ascii_char == CH_NEWLINE)
    else $error("line end without newline character");

  // erase results carry no character
  a_erase_char: assert property (@(posedge clk) disable iff (rst)
    out_valid && ((action == ACT_ERASED) || (action == ACT_ERASE_IGNORED))
      |-> ascii_char == CH_NUL)
    else $error("erase result with a character");

  // results that touch no slot report the line length
  a_no_slot_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && ((action == ACT_LINE_END) || (action == ACT_ERASE_IGNORED)
      || (action == ACT_DROPPED)) |-> line_position == POS_NONE)
    else $error("slotless result with a slot position");

endmodule

bind ps2_set1_line_input ps2l_checker #(
  .LINE_LEN (LINE_LEN)
) u_ps2l_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .ascii_char    (ascii_char),
  .action        (action),
  .line_position (line_position)
);

`default_nettype wire
